/* rtl/core/audio_matrix_mixer_top_macros.svh */
// assertion helpers for the mixer back end
// every use sits in a module that has clock and reset in scope
`ifndef AUDIO_MATRIX_MIXER_TOP_MACROS_SVH
`define AUDIO_MATRIX_MIXER_TOP_MACROS_SVH

// condition that must hold at every edge out of reset
`define AMM_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define AMM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/amm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amm_pkg
// shared types, constants and q31 arithmetic for the audio mixing matrix
// ----------------------------------------------------------------------------
package amm_pkg;

   localparam int NumCh     = 4;
   localparam int NumOsc    = 4;
   localparam int AdcW      = 24;
   localparam int Q31W      = 32;
   localparam int InShift   = 8;
   localparam int IdxW      = 6;

   // coefficient index map
   localparam int OscGainBase = 16;
   localparam int AmpBase     = 32;
   localparam int StoreDepth  = 36;

   // coefficient memory: one row per sequencer step, two sources per row
   localparam int LaneSlots = 2;
   localparam int Steps     = 4;
   localparam int Rows      = Steps;
   localparam int RowWords  = LaneSlots * NumCh + LaneSlots;
   localparam int AmpWord   = LaneSlots * NumCh;
   localparam int StepW     = $clog2(Steps);
   localparam int RowW      = $clog2(Rows);
   localparam int WordW     = $clog2(RowWords);
   localparam int OscRow0   = 2;

   localparam logic [StepW-1:0] FirstStep   = '0;
   localparam logic [StepW-1:0] OscStep0    = StepW'(OscRow0);
   localparam logic [StepW-1:0] LastStep    = StepW'(Steps - 1);

   // command codes
   localparam logic CmdMix   = 1'b0;
   localparam logic CmdWrite = 1'b1;

   localparam int QDepth = 2;

   localparam logic signed [Q31W-1:0] Q31Max = {1'b0, {(Q31W-1){1'b1}}};
   localparam logic signed [Q31W-1:0] Q31Min = {1'b1, {(Q31W-1){1'b0}}};

   typedef struct packed {
      logic                   command;
      logic [IdxW-1:0]        coef_index;
      logic signed [Q31W-1:0] coef_value;
      logic signed [AdcW-1:0] adc_sample_0;
      logic signed [AdcW-1:0] adc_sample_1;
      logic signed [AdcW-1:0] adc_sample_2;
      logic signed [AdcW-1:0] adc_sample_3;
      logic signed [Q31W-1:0] osc_sample_0;
      logic signed [Q31W-1:0] osc_sample_1;
      logic signed [Q31W-1:0] osc_sample_2;
      logic signed [Q31W-1:0] osc_sample_3;
   } req_type;

   typedef struct packed {
      logic signed [AdcW-1:0] dac_sample_0;
      logic signed [AdcW-1:0] dac_sample_1;
      logic signed [AdcW-1:0] dac_sample_2;
      logic signed [AdcW-1:0] dac_sample_3;
   } rsp_type;

   // queue entry: either a coefficient write or a frame to mix
   typedef struct packed {
      logic                        is_write;
      logic [RowW-1:0]             row;
      logic [WordW-1:0]            word;
      logic [Q31W-1:0]             value;
      logic [NumCh-1:0][AdcW-1:0]  adc;
      logic [NumOsc-1:0][Q31W-1:0] osc;
   } qent_type;

   // q31 product, floor shift, only -1 * -1 saturates
   function automatic logic signed [Q31W-1:0] q31_mul(input logic signed [Q31W-1:0] a,
                                                       input logic signed [Q31W-1:0] b);
      logic signed [2*Q31W-1:0] prod;
      logic [Q31W:0]            shr;
      logic signed [Q31W-1:0]   res;
      prod = $signed((2*Q31W)'(a)) * $signed((2*Q31W)'(b));
      shr  = prod[2*Q31W-1:Q31W-1];
      if (shr[Q31W] != shr[Q31W-1]) begin
         res = Q31Max;
      end else begin
         res = $signed(shr[Q31W-1:0]);
      end
      return res;
   endfunction

   function automatic logic signed [Q31W-1:0] q31_add(input logic signed [Q31W-1:0] a,
                                                       input logic signed [Q31W-1:0] b);
      logic signed [Q31W:0]   sum;
      logic signed [Q31W-1:0] res;
      sum = $signed((Q31W+1)'(a)) + $signed((Q31W+1)'(b));
      if (sum[Q31W] != sum[Q31W-1]) begin
         res = sum[Q31W] ? Q31Min : Q31Max;
      end else begin
         res = $signed(sum[Q31W-1:0]);
      end
      return res;
   endfunction

endpackage

/* rtl/core/amm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amm_front
// accepts request beats, decodes coefficient writes, pushes work to the queue
// ----------------------------------------------------------------------------
module amm_front (
   input  logic               req_valid,
   output logic               req_stall,
   input  amm_pkg::req_type   req_payload,
   input  logic               q_full,
   output logic               q_push,
   output amm_pkg::qent_type  q_push_data
);

   logic accept;
   logic in_range;
   logic [amm_pkg::IdxW-1:0] idx;

   always_comb begin
      idx      = req_payload.coef_index;
      accept   = req_valid && !q_full;
      in_range = 1'b1;

      q_push_data          = '0;
      q_push_data.is_write = (req_payload.command == amm_pkg::CmdWrite);
      q_push_data.value    = req_payload.coef_value;
      q_push_data.adc      = {req_payload.adc_sample_3, req_payload.adc_sample_2,
                              req_payload.adc_sample_1, req_payload.adc_sample_0};
      q_push_data.osc      = {req_payload.osc_sample_3, req_payload.osc_sample_2,
                              req_payload.osc_sample_1, req_payload.osc_sample_0};

      if (q_push_data.is_write) begin
         // row = source / 2, word = slot * channels + output
         priority if (idx < amm_pkg::IdxW'(amm_pkg::OscGainBase)) begin
            q_push_data.row  = amm_pkg::RowW'(idx[3]);
            q_push_data.word = {1'b0, idx[2], idx[1:0]};
         end else if (idx < amm_pkg::IdxW'(amm_pkg::AmpBase)) begin
            q_push_data.row  = amm_pkg::RowW'(amm_pkg::OscRow0 + int'(idx[3]));
            q_push_data.word = {1'b0, idx[2], idx[1:0]};
         end else if (idx < amm_pkg::IdxW'(amm_pkg::StoreDepth)) begin
            q_push_data.row  = amm_pkg::RowW'(amm_pkg::OscRow0 + int'(idx[1]));
            q_push_data.word = amm_pkg::WordW'(amm_pkg::AmpWord + int'(idx[0]));
         end else begin
            // index past the store: taken and dropped
            in_range = 1'b0;
         end
      end

      q_push    = accept && in_range;
      req_stall = q_full;
   end

endmodule

/* rtl/core/amm_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amm_queue
// short fifo between the decode front and the mixing back end
// ----------------------------------------------------------------------------
module amm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  amm_pkg::qent_type  push_data,
   output logic               full,
   output logic               head_valid,
   output amm_pkg::qent_type  head_data,
   input  logic               pop
);

   localparam int PtrW = (amm_pkg::QDepth > 1) ? $clog2(amm_pkg::QDepth) : 1;
   localparam int CntW = $clog2(amm_pkg::QDepth + 1);

   amm_pkg::qent_type q_mem_ff [amm_pkg::QDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(amm_pkg::QDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(amm_pkg::QDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full       = (count_ff == CntW'(amm_pkg::QDepth));
   assign head_valid = (count_ff != '0);
   assign head_data  = q_mem_ff[rd_ptr_ff];

endmodule

/* rtl/core/amm_back.sv */
`timescale 1ns / 1ps
`include "audio_matrix_mixer_top_macros.svh"
// ----------------------------------------------------------------------------
// amm_back
// coefficient memory, four-step mixing sequencer and result register
// ----------------------------------------------------------------------------
module amm_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  amm_pkg::qent_type  head_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output amm_pkg::rsp_type   rsp_payload
);

   localparam int W  = amm_pkg::Q31W;
   localparam int LS = amm_pkg::LaneSlots;
   localparam int NC = amm_pkg::NumCh;
   localparam int RW = amm_pkg::RowWords;
   localparam int SW = amm_pkg::StepW;

   logic adv, seq_free, pop_write, pop_frame;

   // sequencer
   logic          busy_ff, busy_in;
   logic [SW-1:0] step_ff, step_in;
   logic [amm_pkg::NumCh-1:0][amm_pkg::AdcW-1:0] frm_adc_ff;
   logic [amm_pkg::NumOsc-1:0][W-1:0]            frm_osc_ff;

   // coefficient memory and per-word valid bits
   logic [RW-1:0][W-1:0]              coef_mem_ff [amm_pkg::Rows];
   logic [amm_pkg::Rows-1:0][RW-1:0]  coef_vld_ff, coef_vld_in;

   // read stage
   logic                  rd_vld_ff, rd_vld_in;
   logic [SW-1:0]         rd_step_ff;
   logic [RW-1:0][W-1:0]  rd_row_ff;
   logic [RW-1:0]         rd_mask_ff;
   logic [LS-1:0][W-1:0]  rd_samp_ff, rd_samp_in;

   // first product stage
   logic                          p_vld_ff, p_vld_in;
   logic [SW-1:0]                 p_step_ff;
   logic [LS-1:0][NC-1:0][W-1:0]  p_ff, p_in;
   logic [LS-1:0][W-1:0]          p_samp_ff;

   // term stage
   logic                          t_vld_ff, t_vld_in;
   logic [SW-1:0]                 t_step_ff;
   logic [LS-1:0][NC-1:0][W-1:0]  t_ff, t_in;

   // accumulators and result
   logic [NC-1:0][W-1:0]  acc_ff, acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   amm_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   logic                  rsp_load;

   always_comb begin
      adv       = !(rsp_valid_ff && rsp_stall);
      seq_free  = !busy_ff || (step_ff == amm_pkg::LastStep);
      pop       = adv && seq_free && head_valid;
      pop_write = pop && head_data.is_write;
      pop_frame = pop && !head_data.is_write;

      busy_in = busy_ff;
      step_in = step_ff;
      if (adv) begin
         if (busy_ff) begin
            step_in = step_ff + 1'b1;
         end
         if (seq_free) begin
            busy_in = pop_frame;
         end
         if (pop_frame) begin
            step_in = amm_pkg::FirstStep;
         end
      end

      coef_vld_in = coef_vld_ff;
      if (pop_write) begin
         coef_vld_in[head_data.row][head_data.word] = 1'b1;
      end
   end

   // operand pairs for the step being issued
   always_comb begin
      logic [$clog2(amm_pkg::NumCh)-1:0] si;
      for (int j = 0; j < LS; j++) begin
         si = {step_ff[0], 1'(j)};
         if (step_ff >= amm_pkg::OscStep0) begin
            rd_samp_in[j] = frm_osc_ff[si];
         end else begin
            rd_samp_in[j] = {frm_adc_ff[si], {amm_pkg::InShift{1'b0}}};
         end
      end
      rd_vld_in = adv ? busy_ff : rd_vld_ff;
   end

   // adc steps: sample * gain; osc steps: gain * amplitude
   always_comb begin
      logic signed [W-1:0] g, a, opa, opb;
      for (int j = 0; j < LS; j++) begin
         for (int c = 0; c < NC; c++) begin
            g = rd_mask_ff[j*NC+c] ? rd_row_ff[j*NC+c] : '0;
            a = rd_mask_ff[amm_pkg::AmpWord+j] ? rd_row_ff[amm_pkg::AmpWord+j] : '0;
            if (rd_step_ff >= amm_pkg::OscStep0) begin
               opa = g;
               opb = a;
            end else begin
               opa = rd_samp_ff[j];
               opb = g;
            end
            p_in[j][c] = amm_pkg::q31_mul(opa, opb);
         end
      end
      p_vld_in = adv ? rd_vld_ff : p_vld_ff;
   end

   // osc steps: scaled gain * oscillator sample
   always_comb begin
      for (int j = 0; j < LS; j++) begin
         for (int c = 0; c < NC; c++) begin
            if (p_step_ff >= amm_pkg::OscStep0) begin
               t_in[j][c] = amm_pkg::q31_mul(p_ff[j][c], p_samp_ff[j]);
            end else begin
               t_in[j][c] = p_ff[j][c];
            end
         end
      end
      t_vld_in = adv ? p_vld_ff : t_vld_ff;
   end

   // saturating accumulation, lane 0 before lane 1
   always_comb begin
      logic signed [W-1:0] sum;
      for (int c = 0; c < NC; c++) begin
         sum = (t_step_ff == amm_pkg::FirstStep) ? '0 : acc_ff[c];
         for (int j = 0; j < LS; j++) begin
            sum = amm_pkg::q31_add(sum, t_ff[j][c]);
         end
         acc_in[c] = sum;
      end
      rsp_load     = adv && t_vld_ff && (t_step_ff == amm_pkg::LastStep);
      rsp_valid_in = adv ? rsp_load : rsp_valid_ff;
      rsp_data_in.dac_sample_0 = acc_in[0][W-1:amm_pkg::InShift];
      rsp_data_in.dac_sample_1 = acc_in[1][W-1:amm_pkg::InShift];
      rsp_data_in.dac_sample_2 = acc_in[2][W-1:amm_pkg::InShift];
      rsp_data_in.dac_sample_3 = acc_in[3][W-1:amm_pkg::InShift];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= amm_pkg::FirstStep;
         coef_vld_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         p_vld_ff     <= 1'b0;
         t_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         coef_vld_ff  <= coef_vld_in;
         rd_vld_ff    <= rd_vld_in;
         p_vld_ff     <= p_vld_in;
         t_vld_ff     <= t_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_write) begin
         coef_mem_ff[head_data.row][head_data.word] <= head_data.value;
      end
      if (pop_frame) begin
         frm_adc_ff <= head_data.adc;
         frm_osc_ff <= head_data.osc;
      end
      if (adv && busy_ff) begin
         rd_row_ff  <= coef_mem_ff[step_ff];
         rd_mask_ff <= coef_vld_ff[step_ff];
         rd_step_ff <= step_ff;
         rd_samp_ff <= rd_samp_in;
      end
      if (adv) begin
         p_ff      <= p_in;
         p_step_ff <= rd_step_ff;
         p_samp_ff <= rd_samp_ff;
         t_ff      <= t_in;
         t_step_ff <= p_step_ff;
      end
      if (adv && t_vld_ff) begin
         acc_ff <= acc_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   `AMM_ASSERT_NEXT(a_frame_starts, pop_frame, busy_ff && step_ff == amm_pkg::FirstStep, "frame did not start at first step")
   `AMM_ASSERT_NEXT(a_last_step_out, rsp_load, rsp_valid_ff, "last step gave no result")
   `AMM_ASSERT_NEXT(a_stage_moves, adv && p_vld_ff, t_vld_ff && t_step_ff == $past(p_step_ff), "term stage lost a step")
   `AMM_ASSERT(a_steps_in_order, !(t_vld_ff && p_vld_ff && t_step_ff != amm_pkg::LastStep) || p_step_ff == t_step_ff + 1'b1, "steps out of order")

endmodule

/* rtl/core/audio_matrix_mixer_top.sv */
// path: queue, sequencer, read, product and term stages, then the result register
// frames: the four-step sequencer over coefficient memory (two sources per step)
//   takes a new frame in its last step; coefficient writes wait for a free sequencer
// reset: synchronous, clears control state and marks every coefficient as zero at once
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_matrix_mixer_top
// q31 mixing matrix: four converter inputs and four oscillators to four outputs
// ----------------------------------------------------------------------------
module audio_matrix_mixer_top (
   input  logic              clock,
   input  logic              reset,
   // request channel: mix a frame or write a coefficient
   input  logic              req_valid,
   output logic              req_stall,
   input  amm_pkg::req_type  req_payload,
   // result channel: one beat per mixed frame
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output amm_pkg::rsp_type  rsp_payload
);

   // front to queue
   logic               q_full;
   logic               q_push;
   amm_pkg::qent_type  q_push_data;

   // queue to back end
   logic               q_head_valid;
   amm_pkg::qent_type  q_head_data;
   logic               q_pop;

   // decode: writes get their memory row and word, bad indexes are dropped
   amm_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // keeps writes and frames in arrival order so coefficient updates land
   // between the frames around them
   amm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_data  (q_head_data),
      .pop        (q_pop)
   );

   // memory read, two multiply stages, saturating accumulate, result register;
   // the whole back end holds while a finished result waits
   amm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_head_valid),
      .head_data   (q_head_data),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* tb/tb_audio_matrix_mixer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_matrix_mixer_top
// self-checking bench for the q31 mixing matrix: a queue-fed driver offers
// coefficient writes and frames in random bursts, a scoreboard keeps its own
// copy of the coefficient store, predicts every mixed frame at acceptance and
// checks each result beat field by field while the receiver stalls at random
// ----------------------------------------------------------------------------
module tb_audio_matrix_mixer_top;
   import amm_pkg::*;

   // cycles with no beat on either channel before the run is called hung
   localparam int StallLimit  = 5000;
   // long receiver hold-off that backs the block up into its input
   localparam int HoldCycles  = 300;
   localparam int HoldAfter   = 40;
   // cycles allowed after the last result for trailing coefficient writes
   localparam int DrainCycles = 24;
   localparam int RandomBeats = 550;
   localparam int ReqW        = $bits(req_type);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // beats still to be offered, and mixed frames still owed by the block
   req_type pending_beats[$];
   rsp_type expected_mixes[$];

   // scoreboard copy of the coefficient memory, zero after reset
   logic signed [Q31W-1:0] coef_store [StoreDepth];

   int mismatches     = 0;
   int frames_checked = 0;

   audio_matrix_mixer_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // q31 arithmetic of the mixer, done in 64-bit integers
   // ---------------------------------------------------------------------
   function automatic logic signed [Q31W-1:0] clamp_q31(input longint v);
      if (v > longint'(Q31Max)) begin
         return Q31Max;
      end
      if (v < longint'(Q31Min)) begin
         return Q31Min;
      end
      return v[Q31W-1:0];
   endfunction

   // exact product, floor shift by 31; only -1 times -1 leaves the range
   function automatic logic signed [Q31W-1:0] frac_mul(input logic signed [Q31W-1:0] a,
                                                       input logic signed [Q31W-1:0] b);
      longint prod;
      prod = longint'(a) * longint'(b);
      return clamp_q31(prod >>> 31);
   endfunction

   function automatic logic signed [Q31W-1:0] frac_add(input logic signed [Q31W-1:0] a,
                                                       input logic signed [Q31W-1:0] b);
      return clamp_q31(longint'(a) + longint'(b));
   endfunction

   // one output frame from the current coefficient store
   function automatic rsp_type mix_frame(input req_type beat);
      logic signed [AdcW-1:0] adc [NumCh];
      logic signed [Q31W-1:0] osc [NumOsc];
      logic signed [AdcW-1:0] dac [NumCh];
      logic signed [Q31W-1:0] acc;
      logic signed [Q31W-1:0] gain;
      rsp_type                res;
      adc[0] = beat.adc_sample_0;
      adc[1] = beat.adc_sample_1;
      adc[2] = beat.adc_sample_2;
      adc[3] = beat.adc_sample_3;
      osc[0] = beat.osc_sample_0;
      osc[1] = beat.osc_sample_1;
      osc[2] = beat.osc_sample_2;
      osc[3] = beat.osc_sample_3;
      for (int ch = 0; ch < NumCh; ch++) begin
         acc = '0;
         // converter inputs first, each widened to q31 by the left shift
         for (int src = 0; src < NumCh; src++) begin
            acc = frac_add(acc, frac_mul(Q31W'(adc[src]) <<< InShift,
                                         coef_store[src * NumCh + ch]));
         end
         // then oscillators, gain times amplitude taken first
         for (int o = 0; o < NumOsc; o++) begin
            gain = frac_mul(coef_store[OscGainBase + o * NumCh + ch], coef_store[AmpBase + o]);
            acc  = frac_add(acc, frac_mul(gain, osc[o]));
         end
         dac[ch] = AdcW'(acc >>> InShift);
      end
      res.dac_sample_0 = dac[0];
      res.dac_sample_1 = dac[1];
      res.dac_sample_2 = dac[2];
      res.dac_sample_3 = dac[3];
      return res;
   endfunction

   // accepted request beat: store a coefficient or owe one mixed frame
   task automatic apply_request(input req_type beat);
      if (beat.command == CmdWrite) begin
         // indexes past the store write nothing
         if (beat.coef_index < StoreDepth) begin
            coef_store[beat.coef_index] = beat.coef_value;
         end
      end else begin
         expected_mixes.push_back(mix_frame(beat));
      end
   endtask

   // ---------------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------------
   // full-range values with the corners picked more often than chance
   function automatic logic signed [AdcW-1:0] rand_adc();
      case ($urandom_range(0, 9))
         0: return {1'b0, {(AdcW-1){1'b1}}};
         1: return {1'b1, {(AdcW-1){1'b0}}};
         2: return '0;
         3: return AdcW'($signed($urandom_range(0, 15)) - 8);
         default: return AdcW'($urandom());
      endcase
   endfunction

   function automatic logic signed [Q31W-1:0] rand_q31();
      logic signed [Q31W-1:0] v;
      v = $urandom();
      case ($urandom_range(0, 9))
         0: return Q31Max;
         1: return Q31Min;
         2: return '0;
         3: return '1;
         // small magnitudes keep the accumulator out of saturation
         4, 5, 6: return v >>> $urandom_range(4, 24);
         default: return v;
      endcase
   endfunction

   function automatic req_type coef_write_beat(input logic [IdxW-1:0] idx,
                                               input logic signed [Q31W-1:0] value);
      req_type beat;
      // frame fields ride along as noise, the block must ignore them
      beat              = ReqW'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                                 $urandom(), $urandom(), $urandom(), $urandom()});
      beat.command      = CmdWrite;
      beat.coef_index   = idx;
      beat.coef_value   = value;
      return beat;
   endfunction

   function automatic req_type frame_beat(input logic signed [AdcW-1:0] a0, a1, a2, a3,
                                          input logic signed [Q31W-1:0] o0, o1, o2, o3);
      req_type beat;
      beat.command      = CmdMix;
      beat.coef_index   = IdxW'($urandom());
      beat.coef_value   = $urandom();
      beat.adc_sample_0 = a0;
      beat.adc_sample_1 = a1;
      beat.adc_sample_2 = a2;
      beat.adc_sample_3 = a3;
      beat.osc_sample_0 = o0;
      beat.osc_sample_1 = o1;
      beat.osc_sample_2 = o2;
      beat.osc_sample_3 = o3;
      return beat;
   endfunction

   // ---------------------------------------------------------------------
   // driver: bursts of beats from the pending queue with random gaps
   // ---------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         // beat taken at this edge goes to the scoreboard first
         if (req_valid && !req_stall) begin
            apply_request(req_payload);
         end
         // a stalled beat holds its payload and valid
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               req_payload <= pending_beats.pop_front();
               req_valid   <= 1'b1;
               if (burst_left <= 1) begin
                  // new burst; about one in three has no gap ahead of it
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: result checking and receiver stall pattern
   // ---------------------------------------------------------------------
   int  stall_pct  = 0;
   int  phase_left = 0;
   int  hold_left  = 0;
   logic hold_done = 1'b0;

   task automatic check_sample(input string name, input logic signed [AdcW-1:0] want,
                               input logic signed [AdcW-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         phase_left <= 0;
         hold_left  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_mixes.size() == 0) begin
               $error("result beat with no frame outstanding: %h", rsp_payload);
               mismatches++;
            end else begin
               want = expected_mixes.pop_front();
               check_sample("dac_sample_0", want.dac_sample_0, rsp_payload.dac_sample_0);
               check_sample("dac_sample_1", want.dac_sample_1, rsp_payload.dac_sample_1);
               check_sample("dac_sample_2", want.dac_sample_2, rsp_payload.dac_sample_2);
               check_sample("dac_sample_3", want.dac_sample_3, rsp_payload.dac_sample_3);
            end
            frames_checked++;
         end
         if (hold_left > 0) begin
            // long hold-off in progress, sender keeps offering meanwhile
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (!hold_done && frames_checked >= HoldAfter) begin
            hold_done = 1'b1;
            hold_left <= HoldCycles;
            rsp_stall <= 1'b1;
         end else begin
            // phases of fixed stall density, some with no stalls at all
            if (phase_left == 0) begin
               case ($urandom_range(0, 4))
                  0, 1: stall_pct = 0;
                  2: stall_pct = 30;
                  3: stall_pct = 60;
                  default: stall_pct = 90;
               endcase
               phase_left <= $urandom_range(5, 60);
            end else begin
               phase_left <= phase_left - 1;
            end
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog on cycles with no beat on either channel
   // ---------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      logic signed [AdcW-1:0] amax;
      logic signed [AdcW-1:0] amin;
      for (int i = 0; i < StoreDepth; i++) begin
         coef_store[i] = '0;
      end
      amax = {1'b0, {(AdcW-1){1'b1}}};
      amin = {1'b1, {(AdcW-1){1'b0}}};

      // extreme frame against an all-zero store mixes to silence
      pending_beats.push_back(frame_beat(amax, amin, amax, amin, Q31Max, Q31Min, Q31Max, Q31Min));
      // gains at full and half scale and the smallest negative, on the diagonal and across
      pending_beats.push_back(coef_write_beat(IdxW'(0), Q31Max));
      pending_beats.push_back(coef_write_beat(IdxW'(4), Q31Min));
      pending_beats.push_back(coef_write_beat(IdxW'(5), Q31Min));
      pending_beats.push_back(coef_write_beat(IdxW'(10), 32'sh4000_0000));
      pending_beats.push_back(coef_write_beat(IdxW'(15), '1));
      // oscillator 0 gain and amplitude both -1.0, product saturates
      pending_beats.push_back(coef_write_beat(IdxW'(OscGainBase), Q31Min));
      pending_beats.push_back(coef_write_beat(IdxW'(AmpBase), Q31Min));
      pending_beats.push_back(coef_write_beat(IdxW'(OscGainBase + 7), Q31Max));
      pending_beats.push_back(coef_write_beat(IdxW'(AmpBase + 1), 32'sh4000_0000));
      pending_beats.push_back(coef_write_beat(IdxW'(StoreDepth - 5), Q31Min));
      pending_beats.push_back(coef_write_beat(IdxW'(StoreDepth - 1), Q31Max));
      // indexes past the store must leave it untouched
      pending_beats.push_back(coef_write_beat(IdxW'(StoreDepth), Q31Max));
      pending_beats.push_back(coef_write_beat('1, Q31Min));
      pending_beats.push_back(frame_beat(amax, amax, amax, amax, Q31Max, Q31Max, Q31Max, Q31Max));
      pending_beats.push_back(frame_beat(amin, amin, amin, amin, Q31Min, Q31Min, Q31Min, Q31Min));
      // accumulator driven past both rails
      pending_beats.push_back(frame_beat(amax, amin, '0, '0, Q31Max, '0, '0, '0));
      pending_beats.push_back(frame_beat(amin, amax, '0, '0, Q31Min, '0, '0, '0));
      // tiny values exercise floor rounding on negatives
      pending_beats.push_back(frame_beat(AdcW'(1), AdcW'(-1), AdcW'(1), AdcW'(-1),
                                         Q31W'(1), Q31W'(-1), Q31W'(1), Q31W'(-1)));
      // overwrite a coefficient and mix again
      pending_beats.push_back(coef_write_beat(IdxW'(0), '0));
      pending_beats.push_back(frame_beat(amax, amin, AdcW'(-1), AdcW'(1),
                                         Q31Min, Q31Max, Q31W'(-1), Q31W'(1)));

      // random part: mostly frames, a quarter coefficient writes
      for (int n = 0; n < RandomBeats; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            pending_beats.push_back(coef_write_beat(
               ($urandom_range(0, 9) == 0) ? IdxW'($urandom_range(StoreDepth, 2**IdxW - 1))
                                           : IdxW'($urandom_range(0, StoreDepth - 1)),
               rand_q31()));
         end else begin
            pending_beats.push_back(frame_beat(rand_adc(), rand_adc(), rand_adc(), rand_adc(),
                                               rand_q31(), rand_q31(), rand_q31(), rand_q31()));
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // drain: everything offered, everything owed has come back
      while (pending_beats.size() > 0 || req_valid || expected_mixes.size() > 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);

      if (mismatches == 0 && expected_mixes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
